/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold in the same cycle
`define ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* rtl/sols_pkg.sv */
package sols_pkg;

  localparam int KEY_W   = 32;
  localparam int IDX_W   = 8;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 9;
  localparam int POL_W   = 2;
  localparam int CFG_W   = 9;
  localparam int CFG_I_W = 1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [POL_W-1:0]        policy_t;

  localparam policy_t POL_NONE  = 2'd0;
  localparam policy_t POL_FRONT = 2'd1;
  localparam policy_t POL_TRANS = 2'd2;
  localparam policy_t POL_FREQ  = 2'd3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CFG_I_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_I_W-1:0] REG_LENGTH = 1'b1;

endpackage

/* rtl/self_organizing_list_search.sv */
// Write word: written to the table in the cycle it is accepted, no result, busy stays low.
// Search word: the scan reads one table entry per cycle through a single memory read port;
// a hit at entry p or a miss over L entries (L = length, capped at depth) strobes out_valid.
// After a hit that swaps or updates a count, busy stays high for the write-back (one write port).
// No new word is taken until the previous search and its write-back are done (busy low). No result stall is possible.
// Reset (synchronous, rst_n low): idle, policy none, length 256; table contents are not cleared.
`include "assert_macros.svh"

module self_organizing_list_search import sols_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [IDX_W-1:0]   in_index,
  input  key_t               in_key,
  output logic               out_valid,
  output logic               out_found,
  output logic [POS_W-1:0]   out_position,
  input  logic               cfg_we,
  input  logic [CFG_I_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB_A = 2'd2;
  localparam logic [1:0] ST_WB_B = 2'd3;

  key_t                   key_mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];

  logic [1:0]             state_r, state_nxt;
  policy_t                policy_r;
  logic [LEN_W-1:0]       len_r;
  logic [PW-1:0]          limit;
  logic [PW-1:0]          ptr_r, ptr_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]          rd_tag_r, rd_tag_nxt;
  key_t                   rd_key_r;
  logic [COUNT_WIDTH-1:0] rd_cnt_r;
  key_t                   key_r;
  key_t                   first_key_r, prev_key_r;
  logic [COUNT_WIDTH-1:0] first_cnt_r, prev_cnt_r;

  logic [AW-1:0]          wa1_r, wa1_nxt, wa2_r, wa2_nxt;
  key_t                   wk1_r, wk1_nxt, wk2_r, wk2_nxt;
  logic [COUNT_WIDTH-1:0] wc1_r, wc1_nxt, wc2_r, wc2_nxt;
  logic                   w2_en_r, w2_en_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [POS_W-1:0]       out_pos_r, out_pos_nxt;

  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  key_t                   mem_wk;
  logic [COUNT_WIDTH-1:0] mem_wc;

  logic                   accept, match, at_front, promote, scan_done;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [AW-1:0]          tag_prev;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign match     = rd_vld_r && (rd_key_r == key_r);
  assign at_front  = (rd_tag_r == '0);
  assign tag_prev  = rd_tag_r - AW'(1);
  assign cnt_inc   = (rd_cnt_r == '1) ? rd_cnt_r : rd_cnt_r + COUNT_WIDTH'(1);
  assign promote   = !at_front && (cnt_inc > prev_cnt_r);
  assign scan_done = (ptr_r == limit);

  always_comb begin
    if (32'(len_r) > 32'(TABLE_DEPTH)) begin
      limit = PW'(TABLE_DEPTH);
    end else begin
      limit = PW'(len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_NONE;
      len_r    <= LEN_W'(256);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_POLICY: policy_r <= cfg_data[POL_W-1:0];
        REG_LENGTH: len_r    <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wa1_r;
    mem_wk = wk1_r;
    mem_wc = wc1_r;
    case (state_r)
      ST_IDLE: begin
        mem_we = accept && (in_operation == OP_WRITE) && (32'(in_index) < 32'(TABLE_DEPTH));
        mem_wa = AW'(in_index);
        mem_wk = in_key;
        mem_wc = '0;
      end
      ST_WB_A: mem_we = 1'b1;
      ST_WB_B: begin
        mem_we = 1'b1;
        mem_wa = wa2_r;
        mem_wk = wk2_r;
        mem_wc = wc2_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wk;
      cnt_mem[mem_wa] <= mem_wc;
    end
    rd_key_r <= key_mem[ptr_r[AW-1:0]];
    rd_cnt_r <= cnt_mem[ptr_r[AW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_tag_nxt    = rd_tag_r;
    wa1_nxt       = wa1_r;
    wk1_nxt       = wk1_r;
    wc1_nxt       = wc1_r;
    wa2_nxt       = wa2_r;
    wk2_nxt       = wk2_r;
    wc2_nxt       = wc2_r;
    w2_en_nxt     = w2_en_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_SEARCH)) begin
          state_nxt = ST_SCAN;
          ptr_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          ptr_nxt    = ptr_r + PW'(1);
          rd_vld_nxt = 1'b1;
          rd_tag_nxt = ptr_r[AW-1:0];
        end
        if (match) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = POS_W'(rd_tag_r);
          rd_vld_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
          w2_en_nxt     = 1'b0;
          case (policy_r)
            POL_FRONT: begin
              if (!at_front) begin
                state_nxt = ST_WB_A;
                wa1_nxt   = '0;
                wk1_nxt   = rd_key_r;
                wc1_nxt   = rd_cnt_r;
                w2_en_nxt = 1'b1;
                wa2_nxt   = rd_tag_r;
                wk2_nxt   = first_key_r;
                wc2_nxt   = first_cnt_r;
              end
            end
            POL_TRANS: begin
              if (!at_front) begin
                state_nxt = ST_WB_A;
                wa1_nxt   = tag_prev;
                wk1_nxt   = rd_key_r;
                wc1_nxt   = rd_cnt_r;
                w2_en_nxt = 1'b1;
                wa2_nxt   = rd_tag_r;
                wk2_nxt   = prev_key_r;
                wc2_nxt   = prev_cnt_r;
              end
            end
            POL_FREQ: begin
              state_nxt = ST_WB_A;
              wk1_nxt   = rd_key_r;
              wc1_nxt   = cnt_inc;
              if (promote) begin
                wa1_nxt   = tag_prev;
                w2_en_nxt = 1'b1;
                wa2_nxt   = rd_tag_r;
                wk2_nxt   = prev_key_r;
                wc2_nxt   = prev_cnt_r;
              end else begin
                wa1_nxt   = rd_tag_r;
              end
            end
            default: ;
          endcase
        end else if (scan_done) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          rd_vld_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WB_A: state_nxt = w2_en_r ? ST_WB_B : ST_IDLE;
      ST_WB_B: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      w2_en_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      w2_en_r     <= w2_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    rd_tag_r    <= rd_tag_nxt;
    wa1_r       <= wa1_nxt;
    wk1_r       <= wk1_nxt;
    wc1_r       <= wc1_nxt;
    wa2_r       <= wa2_nxt;
    wk2_r       <= wk2_nxt;
    wc2_r       <= wc2_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    if (accept) begin
      key_r <= in_key;
    end
    if (rd_vld_r) begin
      prev_key_r <= rd_key_r;
      prev_cnt_r <= rd_cnt_r;
      if (at_front) begin
        first_key_r <= rd_key_r;
        first_cnt_r <= rd_cnt_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

  `ASSERT_CLK(a_strobe_single, out_valid_r |=> !out_valid_r, "result strobe repeated")
  `ASSERT_CLK(a_search_busy, (start && !busy && (in_operation == OP_SEARCH)) |=> busy,
              "search word did not start a scan")
  `ASSERT_CLK(a_wb_order, (state_r == ST_WB_B) |-> ($past(state_r) == ST_WB_A),
              "second write-back without first")
  `ASSERT_NOW(a_miss_pos, !(out_valid_r && !out_found_r) || (out_pos_r == '0),
              "miss with nonzero position")

endmodule

/* tb/list_search_monitor.sv */
`timescale 1ns / 100ps

module list_search_monitor import sols_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_operation,
  input  logic [IDX_W-1:0]   in_index,
  input  key_t               in_key,
  input  logic               out_valid,
  input  logic               out_found,
  input  logic [POS_W-1:0]   out_position,
  input  logic               cfg_we,
  input  logic [CFG_I_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 mismatch_count,
  output int                 lookups_open
);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_t;

  key_t                   table_keys [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] hit_counts [TABLE_DEPTH];
  policy_t                policy;
  logic [LEN_W-1:0]       list_len;
  lookup_t                lookups_due [$];

  initial begin
    mismatch_count = 0;
    lookups_open = 0;
    policy = POL_NONE;
    list_len = LEN_W'(256);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      table_keys[i] = '0;
      hit_counts[i] = '0;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic swap_entries(input int a, input int b);
    key_t                   k;
    logic [COUNT_WIDTH-1:0] c;
    k = table_keys[a];
    table_keys[a] = table_keys[b];
    table_keys[b] = k;
    c = hit_counts[a];
    hit_counts[a] = hit_counts[b];
    hit_counts[b] = c;
  endtask

  task automatic scan_and_reorder(input key_t k, output lookup_t res);
    int   span;
    int   p;
    logic hit;
    span = (list_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(list_len);
    hit = 1'b0;
    p = 0;
    for (int i = 0; i < span; i++) begin
      if (!hit && table_keys[i] == k) begin
        hit = 1'b1;
        p = i;
      end
    end
    if (hit) begin
      case (policy)
        POL_FRONT: if (p != 0) swap_entries(p, 0);
        POL_TRANS: if (p != 0) swap_entries(p, p - 1);
        POL_FREQ: begin
          if (hit_counts[p] != '1) hit_counts[p] = hit_counts[p] + 1'b1;
          if (p != 0 && hit_counts[p] > hit_counts[p - 1]) swap_entries(p, p - 1);
        end
        default: ;
      endcase
    end
    res.found = hit;
    res.position = p[POS_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    lookup_t want;
    lookup_t got;
    if (!rst_n) begin
      policy = POL_NONE;
      list_len = LEN_W'(256);
    end else begin
      if (out_valid) begin
        if (lookups_due.size() == 0) begin
          flag_mismatch("result word with no search pending");
        end else begin
          want = lookups_due.pop_front();
          if (out_found !== want.found)
            flag_mismatch($sformatf("found %b, want %b", out_found, want.found));
          if (out_position !== want.position)
            flag_mismatch($sformatf("position %0d, want %0d", out_position, want.position));
        end
      end
      if (start && !busy) begin
        if (in_operation == OP_SEARCH) begin
          scan_and_reorder(in_key, got);
          lookups_due.push_back(got);
        end else if (int'(in_index) < TABLE_DEPTH) begin
          table_keys[in_index] = in_key;
          hit_counts[in_index] = '0;
        end
      end
      if (cfg_we) begin
        if (cfg_idx == REG_POLICY) policy = cfg_data[POL_W-1:0];
        else if (cfg_idx == REG_LENGTH) list_len = cfg_data[LEN_W-1:0];
      end
      lookups_open = lookups_due.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import sols_pkg::*;

  localparam int   DEPTH       = 256;
  localparam int   COUNT_W     = 16;
  localparam int   STALL_LIMIT = 4000;
  localparam key_t KEY_MIN     = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX     = {1'b0, {(KEY_W-1){1'b1}}};
  localparam key_t KEY_ABSENT  = 32'h5A5A_0001;
  localparam key_t KEY_P1      = 32'h0F0F_0F01;
  localparam key_t KEY_P2      = 32'h0F0F_0F02;
  localparam key_t SAT_A       = 32'h1234_5678;
  localparam key_t SAT_B       = 32'hFEDC_BA98;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_operation;
  logic [IDX_W-1:0]   in_index;
  key_t               in_key;
  logic               out_valid;
  logic               out_found;
  logic [POS_W-1:0]   out_position;
  logic               cfg_we;
  logic [CFG_I_W-1:0] cfg_idx;
  logic [CFG_W-1:0]   cfg_data;
  int                 mismatch_count;
  int                 lookups_open;
  int                 stall_cycles;
  logic               steady;
  key_t               key_bank [16];

  self_organizing_list_search #(
    .TABLE_DEPTH(DEPTH),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_index(in_index), .in_key(in_key),
    .out_valid(out_valid), .out_found(out_found), .out_position(out_position),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  list_search_monitor #(
    .TABLE_DEPTH(DEPTH),
    .COUNT_WIDTH(COUNT_W)
  ) monitor (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_index(in_index), .in_key(in_key),
    .out_valid(out_valid), .out_found(out_found), .out_position(out_position),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .lookups_open(lookups_open)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx, input key_t k);
    start = 1'b1;
    in_operation = op;
    in_index = idx;
    in_key = k;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic take_break();
    int roll;
    roll = $urandom_range(0, 99);
    if (!steady && roll >= 70) begin
      start = 1'b0;
      if (roll < 96) repeat ($urandom_range(1, 3)) @(negedge clk);
      else repeat ($urandom_range(10, 40)) @(negedge clk);
    end
  endtask

  // drain pending results and let any swap write-back finish
  task automatic settle();
    start = 1'b0;
    while (lookups_open != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_I_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic key_t pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return key_bank[$urandom_range(0, 15)];
    if (roll == 8) return key_t'($urandom);
    return ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
  endfunction

  initial begin
    int               span;
    logic [LEN_W-1:0] phase_len;
    key_t             k;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_WRITE;
    in_index = '0;
    in_key = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_POLICY;
    cfg_data = '0;
    steady = 1'b0;
    for (int i = 0; i < 16; i++) key_bank[i] = key_t'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill every entry so no search reads an unwritten key
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) k = KEY_MIN;
      else if (i == DEPTH - 1) k = KEY_MAX;
      else if ($urandom_range(0, 3) != 0) k = key_bank[$urandom_range(0, 15)];
      else k = key_t'($urandom);
      send_word(OP_WRITE, i[IDX_W-1:0], k);
      take_break();
    end

    send_word(OP_SEARCH, 8'hFF, KEY_MIN);
    send_word(OP_SEARCH, 8'h00, KEY_MAX);
    send_word(OP_SEARCH, 8'hA5, KEY_ABSENT);
    settle();
    set_register(REG_LENGTH, 9'd0);
    send_word(OP_SEARCH, 8'h00, KEY_MIN);
    settle();
    set_register(REG_LENGTH, 9'd511);
    send_word(OP_SEARCH, 8'h00, KEY_MAX);
    settle();
    set_register(REG_LENGTH, 9'd256);
    set_register(REG_POLICY, CFG_W'(POL_FRONT));
    send_word(OP_SEARCH, 8'h00, KEY_MAX);
    send_word(OP_SEARCH, 8'h00, KEY_MAX);
    settle();
    set_register(REG_POLICY, CFG_W'(POL_TRANS));
    send_word(OP_SEARCH, 8'h00, KEY_MIN);
    send_word(OP_SEARCH, 8'h00, KEY_MIN);
    send_word(OP_SEARCH, 8'h00, KEY_MAX);
    settle();
    set_register(REG_POLICY, CFG_W'(POL_FREQ));
    send_word(OP_WRITE, 8'd1, KEY_P1);
    send_word(OP_WRITE, 8'd2, KEY_P2);
    send_word(OP_SEARCH, 8'h00, KEY_P2);
    send_word(OP_SEARCH, 8'h00, KEY_P1);
    send_word(OP_SEARCH, 8'h00, KEY_P1);

    // raise the front count, then check a fresh hit behind it does not pass it
    settle();
    set_register(REG_LENGTH, 9'd2);
    send_word(OP_WRITE, 8'd0, SAT_A);
    send_word(OP_WRITE, 8'd1, SAT_B);
    repeat (8) send_word(OP_SEARCH, 8'h00, SAT_A);
    send_word(OP_SEARCH, 8'h00, SAT_B);
    send_word(OP_SEARCH, 8'h00, SAT_A);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      if (phase == 0) phase_len = 9'd1;
      else if (phase == 1) phase_len = 9'd256;
      else if (phase == 2) phase_len = LEN_W'($urandom_range(257, 511));
      else phase_len = LEN_W'($urandom_range(2, 40));
      set_register(REG_POLICY, CFG_W'(policy_t'(phase % 4)));
      set_register(REG_LENGTH, phase_len);
      span = (phase_len > DEPTH) ? DEPTH : int'(phase_len);
      steady = (phase % 3 == 2);
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 99) < 85)
            send_word(OP_WRITE, IDX_W'($urandom_range(0, span - 1)), pick_key());
          else
            send_word(OP_WRITE, IDX_W'($urandom_range(0, DEPTH - 1)), key_t'($urandom));
        end else begin
          send_word(OP_SEARCH, IDX_W'($urandom), pick_key());
        end
        take_break();
      end
    end

    start = 1'b0;
    while (lookups_open != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && lookups_open == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
